// File: sv/lgws_pkg.sv
// Shared constants, codes and types of the load-grouped warp scheduler.
package lgws_pkg;

  localparam int WARPS  = 32;
  localparam int GROUPS = 16;
  localparam int IW     = $clog2(WARPS);
  localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;

  // Command codes carried in the command field.
  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_ISSUE = 3'd1,
    CMD_EXEC  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // One entry of the priority list.
  typedef struct packed {
    logic [IW-1:0] id;
    logic          mark;
  } slot_t;

  // Move of one entry from position src to position dst.
  typedef struct packed {
    logic          en;
    logic [IW-1:0] src;
    logic [IW-1:0] dst;
    slot_t         mv;
  } move_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  warp;
    logic [31:0] load_pc;
    logic [3:0]  group;
    logic        hit_flag;
  } req_t;

  typedef struct packed {
    logic [3:0]  ret_group;
    logic [31:0] group_members;
    logic [4:0]  rank;
    logic [4:0]  order_warp;
    logic        order_bundled;
    logic        last;
  } rsp_t;

endpackage

// File: sv/lgws_req_if.sv
// Command channel of the scheduler.
interface lgws_req_if;
  logic              valid;
  logic              ready;
  lgws_pkg::req_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/lgws_rsp_if.sv
// Result channel of the scheduler.
interface lgws_rsp_if;
  logic              valid;
  logic              ready;
  lgws_pkg::rsp_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: sv/lgws_cell.sv
// One position of the priority list, moving entries to and from its neighbors.
module lgws_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [lgws_pkg::IW-1:0] pos_i,
  input  lgws_pkg::slot_t         left_i,
  input  lgws_pkg::slot_t         right_i,
  input  lgws_pkg::move_t         move_i,
  output lgws_pkg::slot_t         slot_o
);
  import lgws_pkg::*;

  slot_t slot_q, slot_d;

  // Take the moved entry, or shift toward the vacated position.
  always_comb begin
    slot_d = slot_q;
    if (move_i.en) begin
      if (pos_i == move_i.dst) begin
        slot_d = move_i.mv;
      end else if (move_i.src < move_i.dst && pos_i >= move_i.src && pos_i < move_i.dst) begin
        slot_d = right_i;
      end else if (move_i.src > move_i.dst && pos_i > move_i.dst && pos_i <= move_i.src) begin
        slot_d = left_i;
      end
    end
  end

  // After reset the list holds the warps in ascending order, unmarked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '{id: pos_i, mark: 1'b0};
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

// File: sv/lgws_chain.sv
// Row of list cells with the position search and bundled-prefix length.
module lgws_chain (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  lgws_pkg::move_t         move_i,
  input  logic [lgws_pkg::IW-1:0] find_id_i,
  output lgws_pkg::slot_t         head_o,
  output logic [lgws_pkg::IW-1:0] find_pos_o,
  output logic                    find_mark_o,
  output logic                    found_o,
  output logic [lgws_pkg::IW:0]   prefix_o
);
  import lgws_pkg::*;

  slot_t slots [WARPS];

  // The cells; the ends see themselves as their outer neighbor.
  for (genvar k = 0; k < WARPS; k++) begin : g_cell
    lgws_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .pos_i   (IW'(k)),
      .left_i  (slots[(k == 0) ? 0 : k - 1]),
      .right_i (slots[(k == WARPS - 1) ? k : k + 1]),
      .move_i  (move_i),
      .slot_o  (slots[k])
    );
  end

  // Position of the searched warp and length of the marked prefix.
  always_comb begin
    find_pos_o  = '0;
    find_mark_o = 1'b0;
    found_o     = 1'b0;
    prefix_o    = (IW+1)'(WARPS);
    for (int k = WARPS - 1; k >= 0; k--) begin
      if (slots[k].id == find_id_i) begin
        find_pos_o  = IW'(k);
        find_mark_o = slots[k].mark;
        found_o     = 1'b1;
      end
      if (!slots[k].mark) begin
        prefix_o = (IW+1)'(k);
      end
    end
  end

  assign head_o = slots[0];

endmodule

// File: sv/load_grouped_warp_scheduler.sv
// Top level of the load-grouped warp scheduler.
//
//   channel  direction  payload
//   req_i    in         command, warp, load_pc, group, hit_flag
//   rsp_o    out        ret_group, group_members, rank, order_warp, order_bundled, last
//
// Load scans the PC table one warp at a time, then delivers its result.
// Execute moves the group's members through the list cells, one group member bit per
// cycle, then delivers its result.
// Issue and clear go straight to delivery; read gives WARPS items, one per cycle
// while rsp_o is ready.
// Commands are taken only while no item is in work; a stalled result holds the block.
// Reset clears the valid bits, the group table and the list at once; no clearing pass
// is needed.
module load_grouped_warp_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  lgws_req_if.sink    req_i,
  lgws_rsp_if.source  rsp_o
);
  import lgws_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_EXEC = 5'b00100,
    ST_RESP = 5'b01000,
    ST_READ = 5'b10000
  } state_e;

  state_e               state_q;
  logic [IW-1:0]        idx_q;
  logic [WARPS-1:0]     pc_valid_q;
  logic [31:0]          last_pc_q [WARPS];
  logic [WARPS-1:0]     members_q [GROUPS];
  logic [GW-1:0]        ng_q;
  logic [IW-1:0]        w_q;
  logic                 w_ok_q;
  logic [31:0]          pc_q;
  logic [31:0]          base_pc_q;
  logic                 base_ok_q;
  logic                 hit_q;
  logic [WARPS-1:0]     acc_q;
  logic [3:0]           og_q;
  logic [WARPS-1:0]     om_q;

  logic                 in_acc, out_acc, idx_last;
  logic                 w_in_range, g_in_range;
  logic [IW-1:0]        pc_addr;
  logic [WARPS-1:0]     g_members, acc_d, load_vec;
  logic                 scan_match;
  move_t                move;
  slot_t                head;
  logic [IW-1:0]        find_pos;
  logic                 find_mark, found;
  logic [IW:0]          prefix;

  assign in_acc     = req_i.valid && req_i.ready;
  assign out_acc    = rsp_o.valid && rsp_o.ready;
  assign idx_last   = (idx_q == IW'(WARPS - 1));
  assign w_in_range = (32'(req_i.data.warp) < WARPS);
  assign g_in_range = (32'(req_i.data.group) < GROUPS);
  assign g_members  = g_in_range ? members_q[GW'(req_i.data.group)] : '0;

  // One read port on the PC table: the commanded warp at accept, else the scan index.
  assign pc_addr    = (state_q == ST_IDLE) ? IW'(req_i.data.warp) : idx_q;
  assign scan_match = base_ok_q && (idx_q != w_q) && pc_valid_q[pc_addr]
                      && (last_pc_q[pc_addr] == base_pc_q);
  always_comb begin
    acc_d = acc_q;
    acc_d[idx_q] = acc_q[idx_q] | scan_match;
  end
  assign load_vec = members_q[ng_q] | acc_d;

  // List moves: rotation for issue and read, member moves for execute.
  always_comb begin
    move = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && req_i.data.command == CMD_ISSUE) begin
          move = '{en: 1'b1, src: '0, dst: IW'(WARPS - 1), mv: '{id: head.id, mark: 1'b0}};
        end
      end
      ST_EXEC: begin
        if (om_q[idx_q] && found) begin
          if (hit_q) begin
            move.en  = 1'b1;
            move.src = find_pos;
            move.dst = ((IW+1)'(find_pos) < prefix) ? IW'(prefix - 1'b1) : IW'(prefix);
            move.mv  = '{id: idx_q, mark: 1'b1};
          end else begin
            move.en  = !find_mark;
            move.src = find_pos;
            move.dst = IW'(WARPS - 1);
            move.mv  = '{id: idx_q, mark: 1'b0};
          end
        end
      end
      ST_READ: begin
        if (out_acc) begin
          move = '{en: 1'b1, src: '0, dst: IW'(WARPS - 1), mv: head};
        end
      end
      default: move = '0;
    endcase
  end

  lgws_chain u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .move_i      (move),
    .find_id_i   (idx_q),
    .head_o      (head),
    .find_pos_o  (find_pos),
    .find_mark_o (find_mark),
    .found_o     (found),
    .prefix_o    (prefix)
  );

  // Control, valid bits and group table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      pc_valid_q <= '0;
      ng_q       <= '0;
      for (int k = 0; k < GROUPS; k++) begin
        members_q[k] <= '0;
      end
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          if (in_acc) begin
            unique case (req_i.data.command)
              CMD_LOAD:  state_q <= ST_LOAD;
              CMD_EXEC:  state_q <= ST_EXEC;
              CMD_READ:  state_q <= ST_READ;
              CMD_ISSUE: state_q <= ST_RESP;
              CMD_CLEAR: begin
                state_q <= ST_RESP;
                if (g_in_range) begin
                  members_q[GW'(req_i.data.group)] <= '0;
                end
              end
              default:   state_q <= ST_IDLE;
            endcase
          end
        end
        ST_LOAD: begin
          idx_q <= idx_q + 1'b1;
          if (idx_last) begin
            state_q         <= ST_RESP;
            members_q[ng_q] <= load_vec;
            if (|acc_d) begin
              ng_q <= (ng_q == GW'(GROUPS - 1)) ? '0 : ng_q + 1'b1;
            end
            if (w_ok_q) begin
              pc_valid_q[w_q] <= 1'b1;
            end
          end
        end
        ST_EXEC: begin
          idx_q <= idx_q + 1'b1;
          if (idx_last) begin
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_acc) begin
            state_q <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_acc) begin
            idx_q <= idx_q + 1'b1;
            if (idx_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers: PC table, captured command fields and result fields.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      w_q       <= IW'(req_i.data.warp);
      w_ok_q    <= w_in_range;
      pc_q      <= req_i.data.load_pc;
      hit_q     <= req_i.data.hit_flag;
      base_pc_q <= last_pc_q[pc_addr];
      base_ok_q <= w_in_range && pc_valid_q[pc_addr];
      acc_q     <= '0;
      og_q      <= req_i.data.group;
      om_q      <= (req_i.data.command == CMD_CLEAR) ? '0 : g_members;
    end
    if (state_q == ST_LOAD) begin
      acc_q <= acc_d;
      if (idx_last) begin
        og_q <= 4'(ng_q);
        om_q <= load_vec;
        if (w_ok_q) begin
          last_pc_q[w_q] <= pc_q;
        end
      end
    end
  end

  // Result channel.
  assign req_i.ready                = (state_q == ST_IDLE);
  assign rsp_o.valid                = (state_q == ST_RESP) || (state_q == ST_READ);
  assign rsp_o.data.ret_group       = og_q;
  assign rsp_o.data.group_members   = 32'(om_q);
  assign rsp_o.data.rank            = (state_q == ST_READ) ? 5'(idx_q) : 5'd0;
  assign rsp_o.data.order_warp      = (state_q == ST_READ) ? 5'(head.id) : 5'd0;
  assign rsp_o.data.order_bundled   = (state_q == ST_READ) && head.mark;
  assign rsp_o.data.last            = (state_q == ST_READ) ? idx_last : 1'b1;

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.ready && rsp_o.valid))
    else $error("command taken while a result is pending");
  a_exec_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> found)
    else $error("warp missing from the priority list");
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && rsp_o.data.last) |=> req_i.ready)
    else $error("block not idle after its final result");
  a_load_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD && idx_last) |=> (state_q == ST_RESP))
    else $error("load scan did not end in a result");
`endif

endmodule

// File: bench/load_grouped_warp_scheduler_tb.sv
// Self-checking testbench for the load-grouped warp scheduler.
`timescale 1ns / 100ps

module load_grouped_warp_scheduler_tb;
  import lgws_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lgws_req_if req_ch ();
  lgws_rsp_if rsp_ch ();

  load_grouped_warp_scheduler dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch.sink),
    .rsp_o (rsp_ch.source)
  );

  // Clock with an 8 ns period.
  always #4 clk_i = ~clk_i;

  // Predictor state of the scheduler.
  logic [31:0]   pc_table [WARPS];
  logic          pc_seen  [WARPS];
  logic [31:0]   groups   [GROUPS];
  logic [GW-1:0] grp_free;
  logic [IW-1:0] prio_id  [WARPS];
  logic          prio_mark[WARPS];

  req_t pending_cmds[$];
  rsp_t expected_rsps[$];

  int send_idle_pct = 10;
  int recv_idle_pct = 84;
  int hold_req      = 0;
  int hold_done     = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int rsp_seen      = 0;
  int cmd_sent      = 0;

  function automatic logic [31:0] members_of(logic [3:0] g);
    return (g < GROUPS) ? groups[g] : 32'd0;
  endfunction

  function automatic int position_of(int w);
    for (int p = 0; p < WARPS; p++)
      if (prio_id[p] == w) return p;
    return WARPS;
  endfunction

  // Take the entry at position src out and put it back at position dst.
  function automatic void move_entry(int src, int dst, logic mark);
    logic [IW-1:0] id;
    id = prio_id[src];
    for (int k = src; k < WARPS - 1; k++) begin
      prio_id[k]   = prio_id[k + 1];
      prio_mark[k] = prio_mark[k + 1];
    end
    for (int k = WARPS - 1; k > dst; k--) begin
      prio_id[k]   = prio_id[k - 1];
      prio_mark[k] = prio_mark[k - 1];
    end
    prio_id[dst]   = id;
    prio_mark[dst] = mark;
  endfunction

  function automatic rsp_t make_rsp(logic [3:0] g, logic [31:0] m, int r, int w, logic b,
                                    logic l);
    rsp_t rsp;
    rsp.ret_group     = g;
    rsp.group_members = m;
    rsp.rank          = r[4:0];
    rsp.order_warp    = w[4:0];
    rsp.order_bundled = b;
    rsp.last          = l;
    return rsp;
  endfunction

  // Append one expected result.
  function automatic void expect_rsp(rsp_t rsp);
    expected_rsps.insert(expected_rsps.size(), rsp);
  endfunction

  // Update the scheduler state for one command and queue what it produces.
  function automatic void schedule_step(req_t cmd);
    int ret;
    int p;
    int q;
    logic found;
    logic [31:0] bv;
    found = 1'b0;
    case (cmd.command)
      CMD_LOAD: begin
        ret = grp_free;
        if (cmd.warp < WARPS && pc_seen[cmd.warp]) begin
          for (int i = 0; i < WARPS; i++)
            if (i != cmd.warp && pc_seen[i] && pc_table[i] == pc_table[cmd.warp]) begin
              groups[ret][i] = 1'b1;
              found = 1'b1;
            end
        end
        if (found) grp_free = (grp_free >= GROUPS - 1) ? '0 : grp_free + 1'b1;
        if (cmd.warp < WARPS) begin
          pc_table[cmd.warp] = cmd.load_pc;
          pc_seen[cmd.warp]  = 1'b1;
        end
        expect_rsp(make_rsp(ret[3:0], groups[ret], 0, 0, 1'b0, 1'b1));
      end
      CMD_ISSUE: begin
        prio_mark[0] = 1'b0;
        move_entry(0, WARPS - 1, 1'b0);
        expect_rsp(make_rsp(cmd.group, members_of(cmd.group), 0, 0, 1'b0, 1'b1));
      end
      CMD_EXEC: begin
        bv = members_of(cmd.group);
        for (int i = 0; i < WARPS; i++) begin
          if (bv[i]) begin
            p = position_of(i);
            if (p < WARPS) begin
              if (cmd.hit_flag) begin
                q = 0;
                while (q < WARPS && prio_mark[q]) q++;
                if (p < q) q--;
                move_entry(p, q, 1'b1);
              end else if (!prio_mark[p]) begin
                move_entry(p, WARPS - 1, prio_mark[p]);
              end
            end
          end
        end
        expect_rsp(make_rsp(cmd.group, members_of(cmd.group), 0, 0, 1'b0, 1'b1));
      end
      CMD_CLEAR: begin
        if (cmd.group < GROUPS) groups[cmd.group] = '0;
        expect_rsp(make_rsp(cmd.group, members_of(cmd.group), 0, 0, 1'b0, 1'b1));
      end
      CMD_READ: begin
        for (int i = 0; i < WARPS; i++)
          expect_rsp(make_rsp(cmd.group, members_of(cmd.group), i, prio_id[i],
                              prio_mark[i], i == WARPS - 1));
      end
      default: ;
    endcase
  endfunction

  function automatic req_t make_cmd(logic [2:0] c, logic [4:0] w, logic [31:0] pc,
                                    logic [3:0] g, logic h);
    req_t cmd;
    cmd.command   = c;
    cmd.warp      = w;
    cmd.load_pc   = pc;
    cmd.group     = g;
    cmd.hit_flag  = h;
    return cmd;
  endfunction

  // Append one pending item.
  function automatic void queue_cmd(req_t cmd);
    pending_cmds.insert(pending_cmds.size(), cmd);
  endfunction

  // Driver: offers the next pending item, keeping valid up while it waits.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        schedule_step(req_ch.data);
        cmd_sent++;
        pending_cmds.delete(0);
      end
      if (req_ch.valid && !req_ch.ready) begin
        // Hold the item until it is taken.
      end else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= pending_cmds[0];
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver ready, with random stalls and an optional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else if (hold_done != hold_req) begin
      hold_done = hold_req;
      hold_left = 400;
      rsp_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: compares each accepted result with the oldest expected one.
  always @(posedge clk_i) begin
    rsp_t exp_rsp;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      rsp_seen++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: %p", rsp_ch.data);
      end else begin
        exp_rsp = expected_rsps[0];
        expected_rsps.delete(0);
        if (rsp_ch.data !== exp_rsp) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %p, got %p", exp_rsp, rsp_ch.data);
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic add_random(int n);
    int kind;
    logic [4:0] w;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      w = 5'($urandom_range(31));
      // Loads draw from a few PCs so that groups form.
      if (kind < 50)
        queue_cmd(make_cmd(CMD_LOAD, w,
            ($urandom_range(9) == 0) ? $urandom : 32'h1000 + 4 * $urandom_range(3),
            4'($urandom_range(15)), 1'($urandom_range(1))));
      else if (kind < 62)
        queue_cmd(make_cmd(CMD_ISSUE, w, $urandom, 4'($urandom_range(15)),
                           1'($urandom_range(1))));
      else if (kind < 82)
        queue_cmd(make_cmd(CMD_EXEC, w, $urandom, 4'($urandom_range(15)),
                           1'($urandom_range(1))));
      else if (kind < 88)
        queue_cmd(make_cmd(CMD_CLEAR, w, $urandom, 4'($urandom_range(15)),
                           1'($urandom_range(1))));
      else if (kind < 96)
        queue_cmd(make_cmd(CMD_READ, w, $urandom, 4'($urandom_range(15)),
                           1'($urandom_range(1))));
      else
        queue_cmd(make_cmd(3'($urandom_range(7, 5)), w, $urandom,
                           4'($urandom_range(15)), 1'($urandom_range(1))));
    end
  endtask

  // Stimulus and end of run.
  initial begin
    for (int i = 0; i < WARPS; i++) begin
      pc_table[i] = '0;
      pc_seen[i]  = 1'b0;
      prio_id[i]  = i[IW-1:0];
      prio_mark[i] = 1'b0;
    end
    for (int g = 0; g < GROUPS; g++) groups[g] = '0;
    grp_free = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every command, shared PCs, undefined codes.
    queue_cmd(make_cmd(CMD_LOAD, 5'd0, 32'hFFFF_FFFF, 4'd0, 1'b0));
    queue_cmd(make_cmd(CMD_LOAD, 5'd31, 32'hFFFF_FFFF, 4'd15, 1'b1));
    queue_cmd(make_cmd(CMD_LOAD, 5'd5, 32'hFFFF_FFFF, 4'd0, 1'b0));
    queue_cmd(make_cmd(CMD_LOAD, 5'd0, 32'h0, 4'd0, 1'b0));
    queue_cmd(make_cmd(CMD_LOAD, 5'd31, 32'h0, 4'd0, 1'b0));
    queue_cmd(make_cmd(CMD_LOAD, 5'd0, 32'h0, 4'd0, 1'b0));
    queue_cmd(make_cmd(CMD_READ, 5'd0, 32'h0, 4'd0, 1'b0));
    queue_cmd(make_cmd(CMD_EXEC, 5'd0, 32'h0, 4'd0, 1'b1));
    queue_cmd(make_cmd(CMD_EXEC, 5'd0, 32'h0, 4'd1, 1'b0));
    queue_cmd(make_cmd(CMD_ISSUE, 5'd31, 32'h0, 4'd15, 1'b0));
    queue_cmd(make_cmd(CMD_READ, 5'd31, 32'hFFFF_FFFF, 4'd1, 1'b1));
    queue_cmd(make_cmd(CMD_EXEC, 5'd0, 32'h0, 4'd0, 1'b0));
    queue_cmd(make_cmd(CMD_CLEAR, 5'd0, 32'h0, 4'd0, 1'b0));
    queue_cmd(make_cmd(CMD_CLEAR, 5'd0, 32'h0, 4'd15, 1'b0));
    queue_cmd(make_cmd(3'd5, 5'd0, 32'h0, 4'd0, 1'b0));
    queue_cmd(make_cmd(3'd7, 5'd31, 32'hFFFF_FFFF, 4'd15, 1'b1));
    queue_cmd(make_cmd(CMD_READ, 5'd0, 32'h0, 4'd15, 1'b0));
    add_random(130);
    wait_drained();

    // Long receiver hold-off while items keep coming; the block must stall.
    add_random(20);
    hold_req++;
    wait_drained();

    send_idle_pct = 84;
    recv_idle_pct = 10;
    add_random(120);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(120);
    wait_drained();
    repeat (80) @(posedge clk_i);

    $display("Ran %0d commands, checked %0d results: loads, issue, execute hit and miss,",
             cmd_sent, rsp_seen);
    $display("clear, full order reads and undefined codes under varied stalls.");
    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
